FILE: design/tlprq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-level priority ready queue: shared definitions
// Request and result types, queue sizing, priority and request codes and the
// controller state type.
// ----------------------------------------------------------------------------
package tlprq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int IDLE_ID     = 1;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_QUEUES  = 3;

  typedef logic [7:0] tid_t;
  typedef logic [1:0] prio_t;

  localparam prio_t PRIO_LOW    = 2'd0;
  localparam prio_t PRIO_NORMAL = 2'd1;
  localparam prio_t PRIO_HIGH   = 2'd2;
  localparam prio_t PRIO_NEVER  = 2'd3;

  localparam logic REQ_ENQUEUE  = 1'b0;
  localparam logic REQ_SCHEDULE = 1'b1;

  typedef struct packed {
    logic  req_type;
    tid_t  tid;
    prio_t priority_level;
    logic  current_runnable;
  } request_t;

  typedef struct packed {
    tid_t next_thread;
    logic switch_needed;
    logic dropped;
    logic all_empty;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

endpackage
`default_nettype wire

FILE: design/three_level_priority_ready_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-level priority ready queue
// Strict-priority scheduler over three circular FIFOs of thread ids.
// ----------------------------------------------------------------------------
// An enqueue request stores its id if its queue has room and loads its
// result when it is taken; a schedule request pops the head of the highest
// non-empty queue through a registered read of that queue's RAM, and the
// put-back of the current thread is written in the cycle the read data
// returns. Requests are handled one at a time; a new request is taken
// whenever the controller is idle and the result register is free or being
// emptied in the same cycle. Ids travel in three RAMs of QUEUE_DEPTH entries
// that need no clearing, since a slot is read only after it has been written;
// head, tail and fill counts live in flip-flops.
module three_level_priority_ready_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                request_valid,
  output logic                     request_stall,
  input  wire tlprq_pkg::request_t request,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output tlprq_pkg::result_t       result
);

  import tlprq_pkg::*;

  // Queue bookkeeping, indexed low, normal, high.
  logic [PTR_W-1:0] head [NUM_QUEUES];
  logic [PTR_W-1:0] tail [NUM_QUEUES];
  logic [CNT_W-1:0] fill [NUM_QUEUES];
  logic [PTR_W-1:0] head_inc [NUM_QUEUES];
  logic [PTR_W-1:0] tail_inc [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty;

  state_t state, state_next;

  // Fields of a schedule request kept while its pop read is in flight.
  tid_t  cur_id;
  prio_t cur_prio;
  logic  cur_run;
  prio_t sel_q;
  logic  sel_empty;

  // RAM ports.
  logic [NUM_QUEUES-1:0] wr_en;
  logic [NUM_QUEUES-1:0] rd_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      rd_addr;
  tid_t                  rd_data [NUM_QUEUES];

  logic    accept;
  logic    out_free;
  logic    pop_do;
  prio_t   pop_q;
  logic    push_want;
  logic    push_full;
  logic    push_do;
  prio_t   push_prio;
  tid_t    push_id;
  tid_t    chosen;
  logic    sw;
  logic    load;
  result_t result_next;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      nonempty[q] = (fill[q] != '0);
      head_inc[q] = (head[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[q] + 1'b1;
      tail_inc[q] = (tail[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail[q] + 1'b1;
    end
  end

  // The result register is free when it is empty or its result leaves now.
  assign out_free      = !result_valid || !result_stall;
  assign request_stall = (state != ST_IDLE) || !out_free;
  assign accept        = request_valid && !request_stall;

  // Strict priority: high before normal before low.
  always_comb begin
    if (nonempty[PRIO_HIGH]) begin
      pop_q = PRIO_HIGH;
    end else if (nonempty[PRIO_NORMAL]) begin
      pop_q = PRIO_NORMAL;
    end else begin
      pop_q = PRIO_LOW;
    end
  end

  assign chosen = sel_empty ? tid_t'(IDLE_ID) : rd_data[sel_q];
  assign sw     = (chosen != cur_id);

  always_comb begin
    state_next  = state;
    pop_do      = 1'b0;
    push_want   = 1'b0;
    push_prio   = request.priority_level;
    push_id     = request.tid;
    load        = 1'b0;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.req_type == REQ_ENQUEUE) begin
            push_want = 1'b1;
            load      = 1'b1;
          end else begin
            pop_do     = |nonempty;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        push_prio = cur_prio;
        push_id   = cur_id;
        if (out_free) begin
          // The put-back sees the counts after the pop, so a slot freed by
          // the pop can take the current thread.
          push_want                 = sw && cur_run;
          load                      = 1'b1;
          result_next.next_thread   = chosen;
          result_next.switch_needed = sw;
          result_next.all_empty     = sel_empty;
          state_next                = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    result_next.dropped = push_want && !push_do;
  end

  always_comb begin
    case (push_prio)
      PRIO_LOW:    push_full = (fill[PRIO_LOW] == CNT_W'(QUEUE_DEPTH));
      PRIO_NORMAL: push_full = (fill[PRIO_NORMAL] == CNT_W'(QUEUE_DEPTH));
      PRIO_HIGH:   push_full = (fill[PRIO_HIGH] == CNT_W'(QUEUE_DEPTH));
      default:     push_full = 1'b1;
    endcase
  end

  assign push_do = push_want && !push_full;

  always_comb begin
    case (push_prio)
      PRIO_NORMAL: wr_addr = tail_inc[PRIO_NORMAL];
      PRIO_HIGH:   wr_addr = tail_inc[PRIO_HIGH];
      default:     wr_addr = tail_inc[PRIO_LOW];
    endcase
    rd_addr = head[pop_q];
    for (int q = 0; q < NUM_QUEUES; q++) begin
      wr_en[q] = push_do && (push_prio == prio_t'(q));
      rd_en[q] = pop_do && (pop_q == prio_t'(q));
    end
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_store
    tlprq_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (wr_addr),
      .wr_data (push_id),
      .rd_en   (rd_en[g]),
      .rd_addr (rd_addr),
      .rd_data (rd_data[g])
    );
  end

  // A pop and a push never fall in the same cycle: the pop comes with the
  // schedule request and its push in the fetch state after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q] <= '0;
        tail[q] <= PTR_W'(QUEUE_DEPTH - 1);
        fill[q] <= '0;
      end
    end else begin
      state <= state_next;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (rd_en[q]) begin
          head[q] <= head_inc[q];
          fill[q] <= fill[q] - 1'b1;
        end else if (wr_en[q]) begin
          tail[q] <= tail_inc[q];
          fill[q] <= fill[q] + 1'b1;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
    if (accept) begin
      cur_id    <= request.tid;
      cur_prio  <= request.priority_level;
      cur_run   <= request.current_runnable;
      sel_q     <= pop_q;
      sel_empty <= !(|nonempty);
    end
  end

`ifndef SYNTH
  // No queue ever holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill[PRIO_LOW] <= CNT_W'(QUEUE_DEPTH)) && (fill[PRIO_NORMAL] <= CNT_W'(QUEUE_DEPTH))
      && (fill[PRIO_HIGH] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue fill count above depth");

  // An accepted schedule request moves to the fetch state in the next cycle.
  a_sched_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.req_type == REQ_SCHEDULE)) |=> (state == ST_FETCH))
    else $error("schedule request did not enter fetch");

  // An all-empty result always carries the idle thread id.
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.all_empty) |-> (result.next_thread == tid_t'(IDLE_ID)))
    else $error("all_empty result without the idle id");

  // A pop is only issued against a queue that holds an id.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop_do |-> (fill[pop_q] != '0))
    else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

FILE: design/tlprq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module tlprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
